@@ rtl/core/wps_pkg.sv @@
// shared types and codes for the wildcard pattern skip table
package wps_pkg;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 6;
  localparam int SKIP_W   = 7;
  localparam int LEN_OUT_W = 7;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // one stored pattern position
  typedef struct packed {
    logic              wild;
    logic [BYTE_W-1:0] data;
  } entry_t;

endpackage

@@ rtl/core/wps_if.sv @@
// valid/ready channel interfaces for requests and results
interface wps_in_if;
  import wps_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [BYTE_W-1:0]   byte_value;
  logic                is_wildcard;
  logic [POS_W-1:0]    position;

  modport source (output valid, opcode, byte_value, is_wildcard, position, input ready);
  modport sink   (input valid, opcode, byte_value, is_wildcard, position, output ready);
endinterface

interface wps_out_if;
  import wps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [SKIP_W-1:0]    skip;
  logic [1:0]           status;
  logic                 pattern_valid;
  logic [LEN_OUT_W-1:0] pattern_length;

  modport source (output valid, skip, status, pattern_valid, pattern_length, input ready);
  modport sink   (input valid, skip, status, pattern_valid, pattern_length, output ready);
endinterface

@@ rtl/core/wps_store.sv @@
// pattern store: one write port, one read port with registered data
module wps_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  wps_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output wps_pkg::entry_t rd_data
);
  import wps_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/wildcard_pattern_skip_table_core.sv @@
// wildcard pattern skip table: pattern store plus query scan sequencer
//
//   channel | dir | payload
//   --------+-----+---------------------------------------------------
//   in      | in  | opcode, byte_value, is_wildcard, position
//   out     | out | skip, status, pattern_valid, pattern_length
//
// clear, append, unused opcodes, rejected queries and queries at the last
// position finish in the accept cycle; the result sits in the output register
// from the next cycle. any other query walks the store one entry per cycle
// from j+1 up to k, k the hit position or else the last position. the single
// read port of the store sets this pace. a new beat is taken only
// while no scan runs and the output register is empty or being drained; rst
// clears the length, the store needs no clearing pass.
module wildcard_pattern_skip_table_core #(
  parameter int MAX_LEN = 64
) (
  input logic     clk,
  input logic     rst,
  wps_in_if.sink  in,
  wps_out_if.source out
);
  import wps_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = (LW > SKIP_W) ? LW : SKIP_W;

  state_t            state, state_next;
  logic [LW-1:0]     length, length_next;
  logic              last_wild, last_wild_next;
  logic [LW-1:0]     k, k_next;
  logic [POS_W-1:0]  j_q, j_next;
  logic [BYTE_W-1:0] c_q, c_next;

  logic                 out_valid;
  logic [SKIP_W-1:0]    out_skip;
  status_t              out_status;
  logic                 out_pvalid;
  logic [LEN_OUT_W-1:0] out_len;

  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  entry_t            wr_data, rd_data;

  logic              in_ready, accept, load, hit;
  logic [CW-1:0]     j_ext, jq_ext, len_ext, k_ext, j_inc, k_inc;
  logic [SKIP_W-1:0] ld_skip;
  status_t           ld_status;

  wps_store #(.DEPTH(MAX_LEN), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready = (state == S_IDLE) && (!out_valid || out.ready);
  assign accept   = in.valid && in_ready;
  assign in.ready = in_ready;

  assign j_ext   = CW'(in.position);
  assign jq_ext  = CW'(j_q);
  assign len_ext = CW'(length);
  assign k_ext   = CW'(k);
  assign j_inc   = j_ext + CW'(1);
  assign k_inc   = k_ext + CW'(1);
  assign hit     = rd_data.wild || (rd_data.data == c_q);

  always_comb begin
    state_next     = state;
    length_next    = length;
    last_wild_next = last_wild;
    k_next         = k;
    j_next         = j_q;
    c_next         = c_q;
    wr_en          = 1'b0;
    wr_addr        = length[AW-1:0];
    wr_data        = '{wild: in.is_wildcard, data: in.byte_value};
    rd_addr        = j_inc[AW-1:0];
    load           = 1'b0;
    ld_skip        = '0;
    ld_status      = ST_OK;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in.opcode)
            OP_CLEAR: begin
              length_next    = '0;
              last_wild_next = 1'b0;
              load           = 1'b1;
            end
            OP_APPEND: begin
              load = 1'b1;
              if (length == LW'(MAX_LEN)) begin
                ld_status = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                length_next    = length + LW'(1);
                last_wild_next = in.is_wildcard;
              end
            end
            OP_QUERY: begin
              if (j_ext >= len_ext) begin
                ld_status = ST_RANGE;
                load      = 1'b1;
              end else if (j_inc == len_ext) begin
                ld_skip = SKIP_W'(len_ext - j_ext);
                load    = 1'b1;
              end else begin
                k_next     = j_inc[LW-1:0];
                j_next     = in.position;
                c_next     = in.byte_value;
                state_next = S_SCAN;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // rd_data holds the entry at position k
        rd_addr = k_inc[AW-1:0];
        if (hit) begin
          ld_skip    = SKIP_W'(k_ext - jq_ext);
          load       = 1'b1;
          state_next = S_IDLE;
        end else if (k_inc == len_ext) begin
          ld_skip    = SKIP_W'(len_ext - jq_ext);
          load       = 1'b1;
          state_next = S_IDLE;
        end else begin
          k_next = k_inc[LW-1:0];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      last_wild <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      length    <= length_next;
      last_wild <= last_wild_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k   <= k_next;
    j_q <= j_next;
    c_q <= c_next;
    if (load) begin
      out_skip   <= ld_skip;
      out_status <= ld_status;
      out_pvalid <= (length_next != '0) && !last_wild_next;
      out_len    <= LEN_OUT_W'(CW'(length_next));
    end
  end

  assign out.valid          = out_valid;
  assign out.skip           = out_skip;
  assign out.status         = out_status;
  assign out.pattern_valid  = out_pvalid;
  assign out.pattern_length = out_len;

endmodule

@@ sim/tb_wildcard_pattern_skip_table_core.sv @@
// testbench for the wildcard pattern skip table: directed table, random sequences, scoreboard
`timescale 1ns / 100ps

module tb_wildcard_pattern_skip_table_core;
  import wps_pkg::*;

  localparam int MAX_LEN     = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 2 * MAX_LEN + 8;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    opcode_t           op;
    logic [BYTE_W-1:0] byte_value;
    logic              wild;
    logic [POS_W-1:0]  pos;
  } req_t;

  typedef struct packed {
    logic [SKIP_W-1:0]    skip;
    status_t              status;
    logic                 pattern_valid;
    logic [LEN_OUT_W-1:0] pattern_length;
  } skip_result_t;

  typedef struct packed {
    req_t         req;
    int           reps;
    logic         typed;
    skip_result_t want;
  } dir_row_t;

  localparam skip_result_t NO_WANT = '0;
  localparam int DIR_ROWS = 23;

  // typed expectations only where they follow directly from the row sequence
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{OP_QUERY,  8'h00, 1'b0, 6'd0},  1, 1'b1, '{7'd0,  ST_RANGE, 1'b0, 7'd0}},
    '{'{OP_NONE,   8'h00, 1'b0, 6'd0},  1, 1'b1, '{7'd0,  ST_OK,    1'b0, 7'd0}},
    '{'{OP_APPEND, 8'h00, 1'b0, 6'd0},  1, 1'b1, '{7'd0,  ST_OK,    1'b1, 7'd1}},
    '{'{OP_APPEND, 8'hFF, 1'b0, 6'd63}, 1, 1'b1, '{7'd0,  ST_OK,    1'b1, 7'd2}},
    '{'{OP_APPEND, 8'hAB, 1'b1, 6'd0},  1, 1'b1, '{7'd0,  ST_OK,    1'b0, 7'd3}},
    '{'{OP_APPEND, 8'h41, 1'b0, 6'd0},  1, 1'b1, '{7'd0,  ST_OK,    1'b1, 7'd4}},
    '{'{OP_QUERY,  8'hFF, 1'b0, 6'd0},  1, 1'b0, NO_WANT},
    '{'{OP_QUERY,  8'h41, 1'b1, 6'd1},  1, 1'b0, NO_WANT},
    '{'{OP_QUERY,  8'h77, 1'b0, 6'd2},  1, 1'b0, NO_WANT},
    '{'{OP_QUERY,  8'h00, 1'b0, 6'd3},  1, 1'b0, NO_WANT},
    '{'{OP_QUERY,  8'h00, 1'b0, 6'd4},  1, 1'b1, '{7'd0,  ST_RANGE, 1'b1, 7'd4}},
    '{'{OP_QUERY,  8'hFF, 1'b1, 6'd63}, 1, 1'b1, '{7'd0,  ST_RANGE, 1'b1, 7'd4}},
    '{'{OP_APPEND, 8'h5A, 1'b1, 6'd0},  1, 1'b1, '{7'd0,  ST_OK,    1'b0, 7'd5}},
    '{'{OP_QUERY,  8'h00, 1'b0, 6'd0},  1, 1'b0, NO_WANT},
    '{'{OP_NONE,   8'hFF, 1'b1, 6'd63}, 1, 1'b1, '{7'd0,  ST_OK,    1'b0, 7'd5}},
    '{'{OP_CLEAR,  8'hFF, 1'b1, 6'd63}, 1, 1'b1, '{7'd0,  ST_OK,    1'b0, 7'd0}},
    '{'{OP_APPEND, 8'h5A, 1'b0, 6'd0},  63, 1'b0, NO_WANT},
    '{'{OP_APPEND, 8'hC3, 1'b0, 6'd0},  1, 1'b1, '{7'd0,  ST_OK,    1'b1, 7'd64}},
    '{'{OP_APPEND, 8'h00, 1'b0, 6'd0},  1, 1'b1, '{7'd0,  ST_FULL,  1'b1, 7'd64}},
    '{'{OP_QUERY,  8'h00, 1'b0, 6'd0},  1, 1'b1, '{7'd64, ST_OK,    1'b1, 7'd64}},
    '{'{OP_QUERY,  8'hC3, 1'b0, 6'd62}, 1, 1'b0, NO_WANT},
    '{'{OP_QUERY,  8'h5A, 1'b0, 6'd63}, 1, 1'b0, NO_WANT},
    '{'{OP_CLEAR,  8'h00, 1'b0, 6'd0},  1, 1'b1, '{7'd0,  ST_OK,    1'b0, 7'd0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  wps_in_if  in_ch ();
  wps_out_if out_ch ();

  wildcard_pattern_skip_table_core #(.MAX_LEN(MAX_LEN)) u_top (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: a private copy of the pattern
  entry_t       pat_mem [MAX_LEN];
  int           pat_len;
  skip_result_t pending_results [$];
  skip_result_t want_res;

  int err_cnt;
  int work_cnt;
  int cycle_cnt;
  int phase;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_done;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic skip_result_t apply_to_table(input req_t r);
    skip_result_t res;
    bit           hit;
    res = NO_WANT;
    res.status = ST_OK;
    hit = 1'b0;
    case (r.op)
      OP_CLEAR: begin
        pat_len = 0;
      end
      OP_APPEND: begin
        if (pat_len >= MAX_LEN) begin
          res.status = ST_FULL;
        end else begin
          pat_mem[pat_len].wild = r.wild;
          pat_mem[pat_len].data = r.byte_value;
          pat_len++;
        end
      end
      OP_QUERY: begin
        if (int'(r.pos) >= pat_len) begin
          res.status = ST_RANGE;
        end else begin
          res.skip = SKIP_W'(pat_len - int'(r.pos));
          for (int k = int'(r.pos) + 1; k < pat_len; k++) begin
            if (!hit && (pat_mem[k].wild || pat_mem[k].data == r.byte_value)) begin
              res.skip = SKIP_W'(k - int'(r.pos));
              hit = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    if (pat_len != 0) res.pattern_valid = !pat_mem[pat_len-1].wild;
    res.pattern_length = LEN_OUT_W'(pat_len);
    return res;
  endfunction

  // offer one beat from a falling edge, return at the accepting rising edge
  task automatic issue_request(input req_t r, input logic typed, input skip_result_t want);
    skip_result_t pred;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.opcode      = r.op;
    in_ch.byte_value  = r.byte_value;
    in_ch.is_wildcard = r.wild;
    in_ch.position    = r.pos;
    do @(posedge clk); while (!in_ch.ready);
    pred = apply_to_table(r);
    pending_results.insert(pending_results.size(), typed ? want : pred);
    if (r.op != OP_NONE) work_cnt++;
  endtask

  task automatic run_random(input int quota);
    logic [BYTE_W-1:0] alph [4];
    req_t              r;
    int                stop_at;
    int                plen;
    int                n_q;
    int                pick;
    stop_at = work_cnt + quota;
    while (work_cnt < stop_at) begin
      if ($urandom_range(99) < 85) begin
        // well-formed: clear, build a pattern, then query it
        for (int i = 0; i < 4; i++) alph[i] = BYTE_W'($urandom);
        r.op = OP_CLEAR;
        r.byte_value = BYTE_W'($urandom);
        r.wild = 1'($urandom);
        r.pos = POS_W'($urandom);
        issue_request(r, 1'b0, NO_WANT);
        pick = $urandom_range(99);
        if (pick < 70) plen = $urandom_range(12, 1);
        else if (pick < 90) plen = $urandom_range(63, 13);
        else plen = MAX_LEN + $urandom_range(2, 0);
        for (int i = 0; i < plen; i++) begin
          r.op = OP_APPEND;
          r.wild = ($urandom_range(99) < 15);
          r.byte_value = $urandom_range(1) ? alph[2'($urandom_range(3))] : BYTE_W'($urandom);
          r.pos = POS_W'($urandom);
          issue_request(r, 1'b0, NO_WANT);
        end
        if (plen > MAX_LEN) plen = MAX_LEN;
        n_q = $urandom_range(12, 1);
        for (int i = 0; i < n_q; i++) begin
          r.op = OP_QUERY;
          r.wild = 1'($urandom);
          r.byte_value = ($urandom_range(99) < 60) ? alph[2'($urandom_range(3))]
                                                    : BYTE_W'($urandom);
          r.pos = ($urandom_range(99) < 85) ? POS_W'($urandom_range(plen - 1, 0))
                                             : POS_W'($urandom);
          issue_request(r, 1'b0, NO_WANT);
        end
      end else begin
        // noise on top of whatever pattern is left
        n_q = $urandom_range(6, 1);
        for (int i = 0; i < n_q; i++) begin
          r.op = opcode_t'($urandom_range(3));
          r.byte_value = BYTE_W'($urandom);
          r.wild = 1'($urandom);
          r.pos = POS_W'($urandom);
          issue_request(r, 1'b0, NO_WANT);
        end
      end
    end
  endtask

  // result side: random stalls plus one long hold-off when the last phase starts
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 1, 0);
      end else begin
        want_res = pending_results.pop_front();
        if (out_ch.skip !== want_res.skip)
          report_mismatch("skip", out_ch.skip, want_res.skip);
        if (out_ch.status !== want_res.status)
          report_mismatch("status", out_ch.status, want_res.status);
        if (out_ch.pattern_valid !== want_res.pattern_valid)
          report_mismatch("pattern_valid", out_ch.pattern_valid, want_res.pattern_valid);
        if (out_ch.pattern_length !== want_res.pattern_length)
          report_mismatch("pattern_length", out_ch.pattern_length, want_res.pattern_length);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    err_cnt = 0;
    work_cnt = 0;
    cycle_cnt = 0;
    pat_len = 0;
    hold_done = 1'b0;
    phase = 0;
    send_idle_pct = 6;
    recv_stall_pct = 86;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_NONE;
    in_ch.byte_value = '0;
    in_ch.is_wildcard = 1'b0;
    in_ch.position = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      for (int n = 0; n < DIR_TAB[i].reps; n++)
        issue_request(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].want);
    end
    run_random(600);

    phase = 1;
    send_idle_pct = 86;
    recv_stall_pct = 6;
    run_random(640);

    phase = 2;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(640);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
